### design/directional_movement_index_unit_assert.svh
// Assertion macros shared by the directional movement index design files.
// Included by every module that carries concurrent assertions.
`ifndef DIRECTIONAL_MOVEMENT_INDEX_UNIT_ASSERT_SVH
`define DIRECTIONAL_MOVEMENT_INDEX_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DMI_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DMI_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define DMI_ASSERT(label, clk, rst, prop, msg)
`define DMI_NEVER(label, clk, rst, expr, msg)
`endif
`endif

### design/dmi_pkg.sv
`timescale 1ns / 1ps
// Package for the directional movement index unit: sequencer states, register codes,
// fixed constants and the divider status group. No dependencies.
package dmi_pkg;

  localparam int PERCENT          = 100;
  localparam int OUT_BITS         = 23;
  localparam int WINDOW_REG_BITS  = 7;
  localparam int AVERAGE_REG_BITS = 6;
  localparam int WINDOW_LIMIT     = 90;
  localparam int AVERAGE_LIMIT    = 60;
  localparam int WINDOW_RESET     = 14;
  localparam int AVERAGE_RESET    = 6;

  typedef enum logic [0:0] {
    REG_WINDOW_LENGTH,
    REG_AVERAGE_LENGTH
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOTAL,
    ST_DIV_P,
    ST_DIV_M,
    ST_DIV_X,
    ST_AVG,
    ST_DIV_A,
    ST_RATE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### design/dmi_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module dmi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### design/dmi_divider.sv
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle, for a quotient known to fit QW bits.
// Depends on dmi_pkg and the assertion macro header.
`include "directional_movement_index_unit_assert.svh"
module dmi_divider #(
  parameter int XW = 62,
  parameter int DW = 39,
  parameter int QW = 23
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [XW-1:0]        dividend,
  input  logic [DW-1:0]        divisor,
  output logic [QW-1:0]        quotient,
  output dmi_pkg::div_status_t status
);

  localparam int CNW = $clog2(QW);

  logic [DW-1:0]    rem;
  logic [QW-1:0]    low;
  logic [DW-1:0]    dvs;
  logic [CNW-1:0]   count;
  logic             busy;
  logic             done;
  logic [XW+DW-1:0] x_ext;
  logic [DW:0]      trial;
  logic [DW:0]      diff;

  assign x_ext = {{DW{1'b0}}, dividend};
  assign trial = {rem, low[QW-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        rem   <= x_ext[QW+DW-1:QW];
        low   <= dividend[QW-1:0];
        dvs   <= divisor;
        count <= CNW'(QW - 1);
      end else if (busy) begin
        if (!diff[DW]) begin
          rem <= diff[DW-1:0];
        end else begin
          rem <= trial[DW-1:0];
        end
        quotient <= {quotient[QW-2:0], !diff[DW]};
        low      <= {low[QW-2:0], 1'b0};
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - 1'b1;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;

  `DMI_NEVER(a_start_while_busy, clk, rst, start && busy, "divider started while busy")
  `DMI_ASSERT(a_done_after_busy, clk, rst, done |-> $past(busy), "done without a run")

endmodule

### design/directional_movement_index_unit.sv
`timescale 1ns / 1ps
// Directional movement index unit (PDI, MDI, ADX, ADXR) over a stream of price bars.
// Depends on dmi_pkg, dmi_ram, dmi_divider and the assertion macro header.
//
// One bar is taken at a time; while it is worked on, in_stall is high. The time a bar
// takes is set by the single shared restoring divider, which carries out up to four
// divisions per bar (PDI, MDI, DX and ADX), and none when no value is defined. The
// result word sits in an output register, so the next bar is taken while it waits.
// A configuration write clears the history as reset does, and takes effect at once;
// no clearing pass is needed.
`include "directional_movement_index_unit_assert.svh"
module directional_movement_index_unit #(
  parameter int MAX_WINDOW    = 128,
  parameter int MAX_AVERAGE   = 64,
  parameter int PRICE_BITS    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [0:0]                     cfg_index,
  input  logic [6:0]                     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [PRICE_BITS-1:0]          bar_high,
  input  logic [PRICE_BITS-1:0]          bar_low,
  input  logic [PRICE_BITS-1:0]          bar_close,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [dmi_pkg::OUT_BITS-1:0]   plus_index,
  output logic [dmi_pkg::OUT_BITS-1:0]   minus_index,
  output logic                           index_valid,
  output logic [dmi_pkg::OUT_BITS-1:0]   average_index,
  output logic                           average_valid,
  output logic [dmi_pkg::OUT_BITS-1:0]   average_rating,
  output logic                           rating_valid
);

  localparam int PB  = PRICE_BITS;
  localparam int OW  = dmi_pkg::OUT_BITS;
  localparam int TW  = PB + $clog2(MAX_WINDOW);
  localparam int QW  = FRACTION_BITS + 7;
  localparam int DW  = (TW >= QW + 1) ? TW : QW + 1;
  localparam int NW  = DW + 7;
  localparam int XW  = NW + FRACTION_BITS;
  localparam int RW  = QW + $clog2(MAX_AVERAGE);
  localparam int WPW = $clog2(MAX_WINDOW);
  localparam int APW = $clog2(MAX_AVERAGE);
  localparam int MCW = $clog2(MAX_AVERAGE + 1);
  localparam int WIN_MAX = (dmi_pkg::WINDOW_LIMIT < MAX_WINDOW) ?
                           dmi_pkg::WINDOW_LIMIT : MAX_WINDOW;
  localparam int AVG_MAX = (dmi_pkg::AVERAGE_LIMIT < MAX_AVERAGE) ?
                           dmi_pkg::AVERAGE_LIMIT : MAX_AVERAGE;
  localparam logic [QW-1:0] PCT_FULL = QW'(dmi_pkg::PERCENT) << FRACTION_BITS;

  dmi_pkg::state_t state, state_next;
  logic launch, launch_next;

  logic [6:0]           window_length;
  logic [5:0]           average_length;
  logic [6:0]           win_clamped;
  logic [5:0]           avg_clamped;
  logic [PB-1:0]        previous_high, previous_low, previous_close;
  logic [7:0]           bars_seen;
  logic                 first_pass;
  logic [PB-1:0]        tr, pm, mm;
  logic [TW-1:0]        range_total, plus_total, minus_total;
  logic [WPW-1:0]       window_position;
  logic [APW-1:0]       average_position;
  logic                 index_ok, dx_ok, adx_ok;
  logic [QW-1:0]        pdi, mdi, dx, adx;
  logic [RW-1:0]        ratio_total;
  logic [MCW-1:0]       ratio_missing_count;
  logic [MAX_AVERAGE-1:0] ratio_present, adx_present;

  logic in_acc, emit_ok;

  // Bar arithmetic on the input word.
  logic signed [PB:0] hh, ll, pc, ph, pl, t0, d2, d3, tmax, hd, ld;
  logic [PB-1:0]      tr_in, pm_in, mm_in;

  // Window ring.
  logic [3*PB-1:0]    win_rdata;
  logic [PB-1:0]      old_tr, old_pm, old_mm;
  logic [TW-1:0]      range_n, plus_n, minus_n;
  logic               index_ok_n;
  logic [WPW:0]       wp_inc;
  logic [APW:0]       ap_inc;

  // Divider.
  logic                 div_start;
  logic [XW-1:0]        div_dividend;
  logic [DW-1:0]        div_divisor;
  logic [QW-1:0]        div_quot;
  dmi_pkg::div_status_t div_stat;
  logic [QW-1:0]        pdi_q, mdi_q;
  logic [QW:0]          sum_n, sum_r, diff_r;
  logic [NW-1:0]        num_p, num_m, num_x;

  // Averaging.
  logic [QW-1:0]  ratio_rdata, hist_rdata, old_ratio;
  logic [RW-1:0]  ratio_n;
  logic [MCW-1:0] miss_dec, miss_n;
  logic           adx_ok_n, adxr_ok;
  logic [QW:0]    adxr_sum;

  assign in_acc  = in_valid && !in_stall;
  assign in_stall = (state != dmi_pkg::ST_IDLE);
  assign emit_ok = !out_valid || !out_stall;

  always_comb begin
    if (cfg_data < 7'd2) begin
      win_clamped = 7'd2;
    end else if (cfg_data > 7'(WIN_MAX)) begin
      win_clamped = 7'(WIN_MAX);
    end else begin
      win_clamped = cfg_data;
    end
    if (cfg_data[5:0] < 6'd2) begin
      avg_clamped = 6'd2;
    end else if (cfg_data[5:0] > 6'(AVG_MAX)) begin
      avg_clamped = 6'(AVG_MAX);
    end else begin
      avg_clamped = cfg_data[5:0];
    end
  end

  always_comb begin
    hh = $signed({1'b0, bar_high});
    ll = $signed({1'b0, bar_low});
    pc = $signed({1'b0, previous_close});
    ph = $signed({1'b0, previous_high});
    pl = $signed({1'b0, previous_low});
    t0 = hh - ll;
    d2 = hh - pc;
    d3 = pc - ll;
    if (d2 < 0) begin
      d2 = -d2;
    end
    if (d3 < 0) begin
      d3 = -d3;
    end
    tmax = t0;
    if (d2 > tmax) begin
      tmax = d2;
    end
    if (d3 > tmax) begin
      tmax = d3;
    end
    hd = hh - ph;
    ld = pl - ll;
    tr_in = '0;
    pm_in = '0;
    mm_in = '0;
    if (bars_seen != 8'd0) begin
      tr_in = tmax[PB-1:0];
      if (hd > 0 && hd > ld) begin
        pm_in = hd[PB-1:0];
      end
      if (ld > 0 && ld > hd) begin
        mm_in = ld[PB-1:0];
      end
    end
  end

  always_comb begin
    old_tr = first_pass ? '0 : win_rdata[3*PB-1:2*PB];
    old_pm = first_pass ? '0 : win_rdata[2*PB-1:PB];
    old_mm = first_pass ? '0 : win_rdata[PB-1:0];
    range_n = range_total - TW'(old_tr) + TW'(tr);
    plus_n  = plus_total - TW'(old_pm) + TW'(pm);
    minus_n = minus_total - TW'(old_mm) + TW'(mm);
    index_ok_n = (bars_seen >= ({1'b0, window_length} + 8'd1)) && (range_n != '0);
    wp_inc = {1'b0, window_position} + 1'b1;
    ap_inc = {1'b0, average_position} + 1'b1;
  end

  always_comb begin
    pdi_q = (plus_total > range_total) ? PCT_FULL : div_quot;
    mdi_q = (minus_total > range_total) ? PCT_FULL : div_quot;
    sum_n = {1'b0, pdi} + {1'b0, mdi_q};
    sum_r = {1'b0, pdi} + {1'b0, mdi};
    diff_r = (pdi > mdi) ? {1'b0, pdi - mdi} : {1'b0, mdi - pdi};
    num_p = NW'(plus_total) * NW'(dmi_pkg::PERCENT);
    num_m = NW'(minus_total) * NW'(dmi_pkg::PERCENT);
    num_x = NW'(diff_r) * NW'(dmi_pkg::PERCENT);
    div_start = launch;
    case (state)
      dmi_pkg::ST_DIV_P: begin
        div_dividend = {num_p, {FRACTION_BITS{1'b0}}};
        div_divisor  = DW'(range_total);
      end
      dmi_pkg::ST_DIV_M: begin
        div_dividend = {num_m, {FRACTION_BITS{1'b0}}};
        div_divisor  = DW'(range_total);
      end
      dmi_pkg::ST_DIV_X: begin
        div_dividend = {num_x, {FRACTION_BITS{1'b0}}};
        div_divisor  = DW'(sum_r);
      end
      dmi_pkg::ST_DIV_A: begin
        div_dividend = XW'(ratio_total);
        div_divisor  = DW'(average_length);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  always_comb begin
    old_ratio = ratio_present[average_position] ? ratio_rdata : '0;
    ratio_n = ratio_total - RW'(old_ratio) + (dx_ok ? RW'(dx) : '0);
    if (ratio_present[average_position]) begin
      miss_dec = ratio_missing_count;
    end else if (ratio_missing_count != '0) begin
      miss_dec = ratio_missing_count - 1'b1;
    end else begin
      miss_dec = ratio_missing_count;
    end
    miss_n = dx_ok ? miss_dec : miss_dec + 1'b1;
    adx_ok_n = (miss_n == '0);
    adxr_ok = adx_ok && adx_present[average_position];
    adxr_sum = {1'b0, adx} + {1'b0, hist_rdata};
  end

  always_comb begin
    state_next  = state;
    launch_next = 1'b0;
    case (state)
      dmi_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_next = dmi_pkg::ST_TOTAL;
        end
      end
      dmi_pkg::ST_TOTAL: begin
        if (index_ok_n) begin
          state_next  = dmi_pkg::ST_DIV_P;
          launch_next = 1'b1;
        end else begin
          state_next = dmi_pkg::ST_AVG;
        end
      end
      dmi_pkg::ST_DIV_P: begin
        if (div_stat.done) begin
          state_next  = dmi_pkg::ST_DIV_M;
          launch_next = 1'b1;
        end
      end
      dmi_pkg::ST_DIV_M: begin
        if (div_stat.done) begin
          if (sum_n != '0) begin
            state_next  = dmi_pkg::ST_DIV_X;
            launch_next = 1'b1;
          end else begin
            state_next = dmi_pkg::ST_AVG;
          end
        end
      end
      dmi_pkg::ST_DIV_X: begin
        if (div_stat.done) begin
          state_next = dmi_pkg::ST_AVG;
        end
      end
      dmi_pkg::ST_AVG: begin
        if (adx_ok_n) begin
          state_next  = dmi_pkg::ST_DIV_A;
          launch_next = 1'b1;
        end else begin
          state_next = dmi_pkg::ST_RATE;
        end
      end
      dmi_pkg::ST_DIV_A: begin
        if (div_stat.done) begin
          state_next = dmi_pkg::ST_RATE;
        end
      end
      dmi_pkg::ST_RATE: begin
        if (emit_ok) begin
          state_next = dmi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dmi_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= dmi_pkg::ST_IDLE;
      launch <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= launch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == dmi_pkg::ST_RATE && emit_ok) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      if (rst) begin
        window_length  <= 7'(dmi_pkg::WINDOW_RESET);
        average_length <= 6'(dmi_pkg::AVERAGE_RESET);
        ratio_missing_count <= MCW'(dmi_pkg::AVERAGE_RESET);
      end else if (cfg_index == dmi_pkg::REG_WINDOW_LENGTH) begin
        window_length <= win_clamped;
        ratio_missing_count <= MCW'(average_length);
      end else begin
        average_length <= avg_clamped;
        ratio_missing_count <= MCW'(avg_clamped);
      end
      previous_high    <= '0;
      previous_low     <= '0;
      previous_close   <= '0;
      bars_seen        <= '0;
      range_total      <= '0;
      plus_total       <= '0;
      minus_total      <= '0;
      window_position  <= '0;
      average_position <= '0;
      ratio_total      <= '0;
      ratio_present    <= '0;
      adx_present      <= '0;
    end else begin
      case (state)
        dmi_pkg::ST_IDLE: begin
          if (in_acc) begin
            tr <= tr_in;
            pm <= pm_in;
            mm <= mm_in;
            first_pass <= (bars_seen < {1'b0, window_length});
            previous_high  <= bar_high;
            previous_low   <= bar_low;
            previous_close <= bar_close;
            if (bars_seen != 8'hFF) begin
              bars_seen <= bars_seen + 8'd1;
            end
          end
        end
        dmi_pkg::ST_TOTAL: begin
          range_total <= range_n;
          plus_total  <= plus_n;
          minus_total <= minus_n;
          index_ok    <= index_ok_n;
          pdi         <= '0;
          mdi         <= '0;
          dx_ok       <= 1'b0;
          if (9'(wp_inc) >= 9'(window_length)) begin
            window_position <= '0;
          end else begin
            window_position <= wp_inc[WPW-1:0];
          end
        end
        dmi_pkg::ST_DIV_P: begin
          if (div_stat.done) begin
            pdi <= pdi_q;
          end
        end
        dmi_pkg::ST_DIV_M: begin
          if (div_stat.done) begin
            mdi <= mdi_q;
          end
        end
        dmi_pkg::ST_DIV_X: begin
          if (div_stat.done) begin
            dx    <= div_quot;
            dx_ok <= 1'b1;
          end
        end
        dmi_pkg::ST_AVG: begin
          ratio_total         <= ratio_n;
          ratio_missing_count <= miss_n;
          ratio_present[average_position] <= dx_ok;
          adx_ok <= adx_ok_n;
          adx    <= '0;
        end
        dmi_pkg::ST_DIV_A: begin
          if (div_stat.done) begin
            adx <= div_quot;
          end
        end
        dmi_pkg::ST_RATE: begin
          if (emit_ok) begin
            adx_present[average_position] <= adx_ok;
            if (8'(ap_inc) >= 8'(average_length)) begin
              average_position <= '0;
            end else begin
              average_position <= ap_inc[APW-1:0];
            end
            plus_index     <= OW'(pdi);
            minus_index    <= OW'(mdi);
            index_valid    <= index_ok;
            average_index  <= OW'(adx);
            average_valid  <= adx_ok;
            average_rating <= adxr_ok ? OW'(adxr_sum[QW:1]) : '0;
            rating_valid   <= adxr_ok;
          end
        end
        default: begin
        end
      endcase
    end
  end

  dmi_ram #(.WIDTH(3 * PB), .DEPTH(MAX_WINDOW)) u_window_ram (
    .clk     (clk),
    .wr_en   (state == dmi_pkg::ST_TOTAL),
    .wr_addr (window_position),
    .wr_data ({tr, pm, mm}),
    .rd_addr (window_position),
    .rd_data (win_rdata)
  );

  dmi_ram #(.WIDTH(QW), .DEPTH(MAX_AVERAGE)) u_ratio_ram (
    .clk     (clk),
    .wr_en   (state == dmi_pkg::ST_AVG),
    .wr_addr (average_position),
    .wr_data (dx_ok ? dx : '0),
    .rd_addr (average_position),
    .rd_data (ratio_rdata)
  );

  dmi_ram #(.WIDTH(QW), .DEPTH(MAX_AVERAGE)) u_history_ram (
    .clk     (clk),
    .wr_en   (state == dmi_pkg::ST_RATE && emit_ok),
    .wr_addr (average_position),
    .wr_data (adx),
    .rd_addr (average_position),
    .rd_data (hist_rdata)
  );

  dmi_divider #(.XW(XW), .DW(DW), .QW(QW)) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .status   (div_stat)
  );

  `DMI_ASSERT(a_index_zero, clk, rst,
              out_valid && !index_valid |-> plus_index == '0 && minus_index == '0,
              "index fields not zero when undefined")
  `DMI_ASSERT(a_rating_needs_average, clk, rst,
              out_valid && rating_valid |-> average_valid,
              "rating defined without average")
  `DMI_NEVER(a_window_position, clk, rst,
             9'(window_position) >= 9'(window_length),
             "window position out of range")

endmodule
